### rtl/core/dhc_pkg.sv
`default_nettype none

package dhc_pkg;

  // Ratio fraction bits; the divider has one stage per quotient bit.
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned DIST_W = 32;
  localparam int unsigned CH_W   = 8;

  // Quotient holds 0..ONE, so one bit above the fraction.
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned REM_W  = DIST_W + 1;
  localparam int unsigned NSTEP  = QW;
  localparam int unsigned T3_W   = QW + 2;
  localparam int unsigned MIX_W  = CH_W + QW;

  localparam logic [DIST_W-1:0] THRESH_RESET = DIST_W'(10000);

  localparam logic [QW-1:0]    RATIO_ONE = QW'(1) << FRAC_BITS;
  localparam logic [MIX_W-1:0] MIX_HALF  = MIX_W'(1) << (FRAC_BITS - 1);

  localparam int unsigned N_CH = 3;
  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;

  typedef logic [1:0] seg_t;

  localparam seg_t SEG_BLUE_CYAN  = 2'd0;
  localparam seg_t SEG_CYAN_YEL   = 2'd1;
  localparam seg_t SEG_YEL_RED    = 2'd2;

  // Ramp stops: blue, cyan, yellow, red.
  localparam logic [CH_W-1:0] STOP_COLOR [4][N_CH] = '{
    '{8'd30,  8'd105, 8'd255},
    '{8'd20,  8'd220, 8'd210},
    '{8'd255, 8'd205, 8'd35},
    '{8'd255, 8'd55,  8'd40}
  };

endpackage

`default_nettype wire

### rtl/core/distance_heat_colormap_unit.sv
// Path: input register, divider stages, segment, product and output registers.
// Throughput: one item per cycle; the 17-stage restoring divider, one
// quotient bit per stage, sets the depth. All stages hold while the output
// waits. Reset clears all valid bits and loads thr_q with 10000.
`default_nettype none

module distance_heat_colormap_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dhc_pkg::DIST_W-1:0]    cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire signed [dhc_pkg::DIST_W-1:0] distance_um_i,
  input  wire                          distance_invalid_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [dhc_pkg::CH_W-1:0]     red_level_o,
  output logic [dhc_pkg::CH_W-1:0]     green_level_o,
  output logic [dhc_pkg::CH_W-1:0]     blue_level_o
);
  import dhc_pkg::*;

  logic [DIST_W-1:0] thr_q;
  logic              en;

  // Divider pipeline: index 0 is the input register.
  logic [NSTEP:0]     vld_q;
  logic [NSTEP:0]     red_q;
  logic [NSTEP:0]     zm_q;
  logic [NSTEP:0]     nz_q;
  logic [REM_W-1:0]   rem_q [NSTEP+1];
  logic [QW-1:0]      quo_q [NSTEP+1];

  logic [DIST_W-1:0]  dist_raw;
  logic [DIST_W-1:0]  dist_clamp;

  // Segment stage.
  logic               seg_vld_q;
  seg_t               seg_q;
  logic [QW-1:0]      amt_q;
  logic [QW-1:0]      ratio;
  logic [T3_W-1:0]    t3;
  seg_t               seg_d;
  logic [QW-1:0]      amt_d;

  // Product stage.
  logic               prd_vld_q;
  logic [MIX_W-1:0]   pa_q [N_CH];
  logic [MIX_W-1:0]   pb_q [N_CH];
  logic [QW-1:0]      amt_inv;
  seg_t               seg_nxt;

  // Output stage.
  logic               out_vld_q;
  logic [CH_W-1:0]    lvl_q [N_CH];
  logic [MIX_W-1:0]   mix_sum [N_CH];

  assign en         = ~out_vld_q | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign dist_raw   = distance_um_i;
  assign dist_clamp = (dist_raw < thr_q) ? dist_raw : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q[0] <= distance_invalid_i | distance_um_i[DIST_W-1];
      zm_q[0]  <= (thr_q == '0);
      nz_q[0]  <= (dist_raw != '0);
      rem_q[0] <= {1'b0, dist_clamp};
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             take;

    // First step tests the integer bit; later steps shift in a zero.
    if (k == 0) begin : g_first
      assign trial = rem_q[k];
    end else begin : g_next
      assign trial = {rem_q[k][REM_W-2:0], 1'b0};
    end

    assign take = (trial >= {1'b0, thr_q});
    assign diff = trial - {1'b0, thr_q};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        red_q[k+1] <= red_q[k];
        zm_q[k+1]  <= zm_q[k];
        nz_q[k+1]  <= nz_q[k];
        rem_q[k+1] <= take ? diff : trial;
        quo_q[k+1] <= {quo_q[k][QW-2:0], take};
      end
    end
  end

  // Zero threshold: exact-match mode overrides the divider.
  assign ratio = zm_q[NSTEP] ? (nz_q[NSTEP] ? RATIO_ONE : '0) : quo_q[NSTEP];
  assign t3    = {2'b00, ratio} + {1'b0, ratio, 1'b0};

  always_comb begin
    if (red_q[NSTEP]) begin
      // Full amount on the last segment lands exactly on red.
      seg_d = SEG_YEL_RED;
      amt_d = RATIO_ONE;
    end else if (t3 <= T3_W'(RATIO_ONE)) begin
      seg_d = SEG_BLUE_CYAN;
      amt_d = t3[QW-1:0];
    end else if (t3 <= (T3_W'(RATIO_ONE) << 1)) begin
      seg_d = SEG_CYAN_YEL;
      amt_d = QW'(t3 - T3_W'(RATIO_ONE));
    end else begin
      seg_d = SEG_YEL_RED;
      amt_d = QW'(t3 - (T3_W'(RATIO_ONE) << 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      seg_vld_q <= vld_q[NSTEP];
      prd_vld_q <= seg_vld_q;
      out_vld_q <= prd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seg_q <= seg_d;
      amt_q <= amt_d;
    end
  end

  assign amt_inv = RATIO_ONE - amt_q;
  assign seg_nxt = seg_q + 2'd1;

  for (genvar c = 0; c < N_CH; c++) begin : g_ch
    always_ff @(posedge clk_i) begin
      if (en) begin
        pa_q[c] <= MIX_W'(STOP_COLOR[seg_q][c]) * MIX_W'(amt_inv);
        pb_q[c] <= MIX_W'(STOP_COLOR[seg_nxt][c]) * MIX_W'(amt_q);
      end
    end

    // Round half up, then drop the fraction.
    assign mix_sum[c] = pa_q[c] + pb_q[c] + MIX_HALF;

    always_ff @(posedge clk_i) begin
      if (en) begin
        lvl_q[c] <= mix_sum[c][FRAC_BITS +: CH_W];
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign red_level_o   = lvl_q[CH_R];
  assign green_level_o = lvl_q[CH_G];
  assign blue_level_o  = lvl_q[CH_B];

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import dhc_pkg::*;

  localparam int unsigned         CYCLE_LIMIT = 500000;
  localparam int unsigned         DRAIN_CYCLES = 40;
  localparam longint unsigned     RATIO_UNIT = 64'd1 << FRAC_BITS;
  localparam logic [DIST_W-1:0]   DIST_MAX = 32'h7FFF_FFFF;

  // Ramp stops, blue -> cyan -> yellow -> red, as {red, green, blue}.
  localparam logic [CH_W-1:0] RAMP_STOP [4][N_CH] = '{
    '{8'd30,  8'd105, 8'd255},
    '{8'd20,  8'd220, 8'd210},
    '{8'd255, 8'd205, 8'd35},
    '{8'd255, 8'd55,  8'd40}
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } heat_rgb_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [DIST_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [DIST_W-1:0] distance_um_i = '0;
  logic                     distance_invalid_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [CH_W-1:0]          red_level_o;
  logic [CH_W-1:0]          green_level_o;
  logic [CH_W-1:0]          blue_level_o;

  logic [DIST_W-1:0] threshold_copy = THRESH_RESET;
  heat_rgb_t         pending_colors[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_burst_left = 0;
  int unsigned       stall_left = 0;
  int unsigned       steady_left = 0;

  distance_heat_colormap_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .distance_um_i      (distance_um_i),
    .distance_invalid_i (distance_invalid_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_level_o        (red_level_o),
    .green_level_o      (green_level_o),
    .blue_level_o       (blue_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CH_W-1:0] blend_level(longint unsigned from_lvl,
                                                   longint unsigned to_lvl,
                                                   longint unsigned amount);
    longint unsigned acc;
    acc = from_lvl * (RATIO_UNIT - amount) + to_lvl * amount + (RATIO_UNIT >> 1);
    return CH_W'(acc >> FRAC_BITS);
  endfunction

  function automatic heat_rgb_t heat_color(logic [DIST_W-1:0] distance, logic invalid,
                                           logic [DIST_W-1:0] threshold);
    longint unsigned ratio;
    longint unsigned t3;
    longint unsigned amount;
    longint unsigned clamped;
    seg_t            seg;
    heat_rgb_t       rgb;
    if (invalid || distance[DIST_W-1]) begin
      rgb.red   = RAMP_STOP[3][CH_R];
      rgb.green = RAMP_STOP[3][CH_G];
      rgb.blue  = RAMP_STOP[3][CH_B];
      return rgb;
    end
    if (threshold == '0) begin
      ratio = (distance == '0) ? 0 : RATIO_UNIT;
    end else begin
      clamped = (distance < threshold) ? distance : threshold;
      ratio = (clamped << FRAC_BITS) / threshold;
    end
    t3 = 3 * ratio;
    if (t3 <= RATIO_UNIT) begin
      seg = SEG_BLUE_CYAN;
      amount = t3;
    end else if (t3 <= 2 * RATIO_UNIT) begin
      seg = SEG_CYAN_YEL;
      amount = t3 - RATIO_UNIT;
    end else begin
      seg = SEG_YEL_RED;
      amount = t3 - 2 * RATIO_UNIT;
    end
    if (amount > RATIO_UNIT) amount = RATIO_UNIT;
    rgb.red   = blend_level(RAMP_STOP[seg][CH_R], RAMP_STOP[seg + 1][CH_R], amount);
    rgb.green = blend_level(RAMP_STOP[seg][CH_G], RAMP_STOP[seg + 1][CH_G], amount);
    rgb.blue  = blend_level(RAMP_STOP[seg][CH_B], RAMP_STOP[seg + 1][CH_B], amount);
    return rgb;
  endfunction

  // Predict at input acceptance; threshold only changes while nothing is in flight.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      pending_colors = {pending_colors,
                        heat_color(distance_um_i, distance_invalid_i, threshold_copy)};
  end

  always @(posedge clk_i) begin
    heat_rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        $error("color item with no prediction pending: %0d %0d %0d",
               red_level_o, green_level_o, blue_level_o);
        error_count++;
      end else begin
        want = pending_colors.pop_front();
        if (red_level_o !== want.red) begin
          $error("red_level: expected %0d, got %0d", want.red, red_level_o);
          error_count++;
        end
        if (green_level_o !== want.green) begin
          $error("green_level: expected %0d, got %0d", want.green, green_level_o);
          error_count++;
        end
        if (blue_level_o !== want.blue) begin
          $error("blue_level: expected %0d, got %0d", want.blue, blue_level_o);
          error_count++;
        end
      end
    end
  end

  // Output back-pressure: short stalls mostly, a few long, some stall-free runs.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (steady_left != 0) begin
      steady_left <= steady_left - 1;
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 31) == 0)
        steady_left <= $urandom_range(20, 80);
      else if ($urandom_range(0, 2) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("distance_heat_colormap_unit verification failed");
      $finish;
    end
  end

  function automatic int unsigned send_gap();
    int unsigned r;
    if (send_burst_left != 0) begin
      send_burst_left--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      send_burst_left = $urandom_range(10, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_item(logic [DIST_W-1:0] distance, logic invalid);
    int unsigned gap;
    gap = send_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_um_i <= distance;
    distance_invalid_i <= invalid;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Step one edge first so the prediction of the last item is queued.
  task automatic drain_items();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [DIST_W-1:0] value);
    drain_items();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_copy = value;
  endtask

  function automatic logic [DIST_W-1:0] pick_distance(logic [DIST_W-1:0] threshold);
    int unsigned       r;
    logic [DIST_W-1:0] span;
    longint            anchor;
    r = $urandom_range(0, 99);
    span = (threshold > DIST_MAX) ? DIST_MAX : threshold;
    if (r < 55) return $urandom_range(0, span);
    if (r < 75) begin
      // land near a segment boundary
      anchor = {32'd0, threshold};
      anchor = anchor * $urandom_range(1, 2) / 3 + $urandom_range(0, 6) - 3;
      if (anchor < 0) anchor = 0;
      if (anchor > DIST_MAX) anchor = DIST_MAX;
      return anchor[DIST_W-1:0];
    end
    if (r < 88) return $urandom_range(span, DIST_MAX);
    return $urandom();
  endfunction

  task automatic run_random_items(int unsigned count);
    repeat (count) send_item(pick_distance(threshold_copy), $urandom_range(0, 15) == 0);
  endtask

  task automatic test_reset_threshold();
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(3333, 1'b0);
    send_item(3334, 1'b0);
    send_item(5000, 1'b0);
    send_item(6666, 1'b0);
    send_item(6667, 1'b0);
    send_item(9999, 1'b0);
    send_item(10000, 1'b0);
    send_item(10001, 1'b0);
    send_item(DIST_MAX, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(0, 1'b1);
    send_item(5000, 1'b1);
    send_item(32'h8000_0000, 1'b1);
  endtask

  task automatic test_exact_match_mode();
    write_threshold('0);
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(DIST_MAX, 1'b0);
    send_item(-5, 1'b0);
    send_item(0, 1'b1);
    run_random_items(15);
  endtask

  task automatic test_unit_threshold();
    write_threshold(1);
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
  endtask

  task automatic test_full_threshold();
    write_threshold(32'hFFFF_FFFF);
    send_item(0, 1'b0);
    send_item(DIST_MAX, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    run_random_items(20);
  endtask

  task automatic test_random_thresholds();
    logic [DIST_W-1:0] choices [7];
    choices = '{32'd3, 32'd10000, 32'd65536, 32'd1000000, DIST_MAX, 32'd0, 32'd0};
    choices[5] = $urandom();
    choices[6] = $urandom_range(2, 300);
    foreach (choices[i]) begin
      write_threshold(choices[i]);
      run_random_items(95);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_threshold();
    test_exact_match_mode();
    test_unit_threshold();
    test_full_threshold();
    test_random_thresholds();
    drain_items();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("distance_heat_colormap_unit verification clean");
    else
      $display("distance_heat_colormap_unit verification failed");
    $finish;
  end

endmodule
